// File: design/asp_pkg.sv
// Shared types and constants for the ASCII signed 16-bit stream parser.
// No dependencies; imported by every module of the block but the checker.
`default_nettype none

package asp_pkg;

   localparam int CHAR_W    = 8;
   localparam int NUM_W     = 16;
   localparam int DIGIT_W   = 4;
   // Magnitude of a number of up to four digits (at most 9999)
   localparam int MAG_W     = 14;
   // Five-digit candidate (at most 99999)
   localparam int CAND_W    = 17;
   localparam int COUNT_W   = 3;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;
   localparam logic [COUNT_W-1:0] MAX_DIGITS = 3'd4;
   localparam logic [CAND_W-1:0]  LIMIT_POS  = 17'd32767;
   localparam logic [CAND_W-1:0]  LIMIT_NEG  = 17'd32768;

   // Item held in the input register
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] char_code;
   } stage_type;

endpackage

`default_nettype wire

// File: design/asp_in_reg.sv
// Input register of the stream parser: captures one byte item per cycle unless the core stalls the held one.
// Depends on asp_pkg.
`default_nettype none

module asp_in_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [asp_pkg::CHAR_W-1:0] in_char,
   input  wire logic                      advance,
   output asp_pkg::stage_type             stage
);
   import asp_pkg::*;

   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;

   // Take a new item whenever the held one leaves or there is none
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (in_ready) begin
         valid_in = in_valid;
         char_in  = in_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign stage.valid     = valid_ff;
   assign stage.char_code = char_ff;

endmodule

`default_nettype wire

// File: design/asp_core.sv
// Parser state update and result register.
// Depends on asp_pkg.
`default_nettype none

module asp_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire asp_pkg::stage_type       stage,
   output logic                          advance,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [asp_pkg::NUM_W-1:0]     out_number
);
   import asp_pkg::*;

   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]   rsp_num_ff, rsp_num_in;

   logic               is_digit;
   logic [DIGIT_W-1:0] digit;
   logic [CAND_W-1:0]  cand;
   logic [CAND_W-1:0]  limit;
   logic [NUM_W-1:0]   mag_wide;
   logic [NUM_W-1:0]   cand_wide;

   assign advance  = stage.valid && (!rsp_valid_ff || out_ready);
   assign is_digit = (stage.char_code >= CHAR_ZERO) && (stage.char_code <= CHAR_NINE);
   assign digit    = DIGIT_W'(stage.char_code - CHAR_ZERO);
   // acc * 10 + d as two shifts and adds
   assign cand     = (CAND_W'(mag_ff) << 3) + (CAND_W'(mag_ff) << 1) + CAND_W'(digit);
   assign limit    = neg_ff ? LIMIT_NEG : LIMIT_POS;
   assign mag_wide  = NUM_W'(mag_ff);
   assign cand_wide = cand[NUM_W-1:0];

   always_comb begin
      mag_in       = mag_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_num_in   = rsp_num_ff;
      if (advance) begin
         if (!is_digit) begin
            if (count_ff != '0) begin
               // Close the number; the closing byte is consumed
               rsp_valid_in = 1'b1;
               rsp_num_in   = neg_ff ? (NUM_W'(0) - mag_wide) : mag_wide;
               mag_in       = '0;
               count_in     = '0;
               neg_in       = 1'b0;
            end else begin
               neg_in = (stage.char_code == CHAR_MINUS);
            end
         end else if (count_ff >= MAX_DIGITS) begin
            rsp_valid_in = 1'b1;
            if (cand > limit) begin
               // Emit the four-digit number, restart with this digit
               rsp_num_in = neg_ff ? (NUM_W'(0) - mag_wide) : mag_wide;
               mag_in     = MAG_W'(digit);
               count_in   = COUNT_W'(1);
               neg_in     = 1'b0;
            end else begin
               rsp_num_in = neg_ff ? (NUM_W'(0) - cand_wide) : cand_wide;
               mag_in     = '0;
               count_in   = '0;
               neg_in     = 1'b0;
            end
         end else begin
            mag_in   = cand[MAG_W-1:0];
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff       <= '0;
         count_ff     <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mag_ff       <= mag_in;
         count_ff     <= count_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_num_ff <= rsp_num_in;
   end

   assign out_valid  = rsp_valid_ff;
   assign out_number = rsp_num_ff;

endmodule

`default_nettype wire

// File: design/ascii_signed_int16_stream_parser_top.sv
// Path: the completing byte of a number is held in the input register, and the number is then
// registered in the result register. Throughput: one byte item per cycle while no result is stalled;
// the accumulator update is combinational between the input register and the result register.
// Reset: synchronous, active high; clears the accumulator, digit count, sign mark
// and both valid flags.
// Top level of the ASCII signed 16-bit parser; depends on asp_pkg, asp_in_reg, asp_core.
`default_nettype none

module ascii_signed_int16_stream_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [15:0] number_out
);
   import asp_pkg::*;

   stage_type stage;
   logic      advance;

   asp_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_char  (req_tdata),
      .advance  (advance),
      .stage    (stage)
   );

   asp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .advance    (advance),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_number (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: design/asp_checker.sv
// Port-level checks for the stream parser, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module asp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // With no result waiting the input side never stalls
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("input stalled while output empty");

   // A fresh result comes from an accepted item that has passed through the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching item");

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind ascii_signed_int16_stream_parser_top asp_checker u_asp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: tb/ascii_signed_int16_stream_parser_top_tb.sv
// Self-checking bench for the ASCII signed 16-bit stream parser: feeds text bytes,
// predicts each emitted number in a scoreboard class and compares it on the result side.
// Depends on asp_pkg and ascii_signed_int16_stream_parser_top.
`default_nettype none

module ascii_signed_int16_stream_parser_top_tb;
   import asp_pkg::*;

   class parsed_number_board;
      logic [15:0]        mag_acc;
      logic [COUNT_W-1:0] digits;
      bit                 neg;
      logic [NUM_W-1:0]   numbers_due[$];
      int                 mismatches;

      function new();
         mag_acc    = '0;
         digits     = '0;
         neg        = 1'b0;
         mismatches = 0;
      endfunction

      function logic [NUM_W-1:0] with_sign(input logic [15:0] mag, input bit is_neg);
         return is_neg ? NUM_W'(16'd0 - mag) : mag;
      endfunction

      function void clear_number();
         mag_acc = '0;
         digits  = '0;
         neg     = 1'b0;
      endfunction

      // Advance the parser state by one accepted byte.
      function void take_char(input logic [CHAR_W-1:0] ch);
         int unsigned d;
         int unsigned cand;
         int unsigned limit;
         if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
            if (digits != 0) begin
               numbers_due.push_back(with_sign(mag_acc, neg));
               clear_number();
            end else begin
               neg = (ch == CHAR_MINUS);
            end
         end else begin
            d = 32'(ch - CHAR_ZERO);
            if (digits >= MAX_DIGITS) begin
               cand  = mag_acc * 10 + d;
               limit = neg ? 32'(LIMIT_NEG) : 32'(LIMIT_POS);
               if (cand > limit) begin
                  // emit the four-digit number, the digit opens a new positive one
                  numbers_due.push_back(with_sign(mag_acc, neg));
                  mag_acc = 16'(d);
                  neg     = 1'b0;
                  digits  = COUNT_W'(1);
               end else begin
                  numbers_due.push_back(with_sign(16'(cand), neg));
                  clear_number();
               end
            end else begin
               mag_acc = 16'(mag_acc * 10 + d);
               digits  = digits + 1'b1;
            end
         end
      endfunction

      function void check_number(input logic [NUM_W-1:0] actual);
         logic [NUM_W-1:0] expected;
         if (numbers_due.size() == 0) begin
            $error("number_out: no number expected, actual %0d", $signed(actual));
            mismatches++;
         end else begin
            expected = numbers_due.pop_front();
            if (actual !== expected) begin
               $error("number_out mismatch: expected %0d, actual %0d",
                      $signed(expected), $signed(actual));
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return numbers_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] char_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] number_out

   parsed_number_board board = new();
   int burst_left   = 0;
   int chars_sent   = 0;
   bit hold_off_req = 1'b0;

   ascii_signed_int16_stream_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_char(input logic [7:0] ch);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      board.take_char(ch);
      burst_left--;
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic logic [7:0] random_separator();
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255)); while (ch >= CHAR_ZERO && ch <= CHAR_NINE);
      return ch;
   endfunction

   task automatic send_number();
      int    pick;
      int    ndig;
      int    value;
      string text;
      text = "";
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 9) < 4) send_char(CHAR_MINUS);
      if (pick < 2) begin
         // land near the positive and negative limits
         value = $urandom_range(32758, 32779);
         text  = $sformatf("%0d", value);
      end else begin
         ndig = (pick == 9) ? $urandom_range(6, 8) : $urandom_range(1, 5);
         for (int i = 0; i < ndig; i++) text = {text, string'(8'($urandom_range(48, 57)))};
      end
      send_text(text);
      // mostly close with a separator; sometimes run straight into a sign or noise
      if ($urandom_range(0, 9) != 0) send_char(random_separator());
      else if ($urandom_range(0, 1) == 0) send_char(CHAR_MINUS);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Result side: check every accepted item, stall in changing patterns.
   initial begin : result_side
      int mode;
      int left;
      int hold_left;
      int phase;
      mode      = 0;
      left      = 0;
      hold_left = 0;
      phase     = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_number(rsp_tdata);
         if (hold_off_req) begin
            hold_left    = 150;
            hold_off_req = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(4, 40);
         end
         left--;
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (phase % 3 != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      bit paused;
      bit held;
      paused = 1'b0;
      held   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // limits, overflow on the fifth digit, closing sign, sign runs, byte extremes
      send_text("-32768,32767-99999--/:7");
      send_char(8'h00);
      send_char(8'hff);

      while (chars_sent < 775) begin
         if (!held && chars_sent >= 200) begin
            hold_off_req = 1'b1;
            held         = 1'b1;
         end
         if (!paused && chars_sent >= 450) begin
            wait_drained();
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 15) send_char(8'($urandom_range(0, 255)));
         else send_number();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
